### hw/rtl/light_sphere_cull_and_scissor_assert.svh
// Assertion macros shared by the light culling RTL.
`ifndef LIGHT_SPHERE_CULL_AND_SCISSOR_ASSERT_SVH
`define LIGHT_SPHERE_CULL_AND_SCISSOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define LSC_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("light cull check failed");

// Check that a condition implies another in the next cycle.
`define LSC_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("light cull check failed");

`endif

### hw/rtl/lsc_pkg.sv
// Shared types, codes and constants of the light culling block.
`default_nettype none

package lsc_pkg;

    localparam int FRACTION_BITS_DEF   = 16;
    localparam int MAX_SCREEN_SIZE_DEF = 16384;

    localparam int WORD_W     = 32;
    localparam int DEN_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Transform table layout
    localparam int TBL_ROW_STRIDE = 4;
    localparam int TBL_CAM_BASE   = 20;

    // Input item kinds
    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam logic KIND_CLASSIFY    = 1'b1;

    // Register reset values
    localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd1920;
    localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd1080;
    localparam logic [30:0] RST_NEAR_PLANE    = 31'd6554;
    localparam logic [15:0] RST_W_EPSILON     = 16'd7;
    localparam logic        RST_CULL_OUTSIDE  = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_NEAR_PLANE    = 3'd2,
        CFG_W_EPSILON     = 3'd3,
        CFG_CULL_OUTSIDE  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ACC_FULL_VIEW      = 3'd0,
        ACC_CULLED         = 3'd1,
        ACC_CAMERA_INSIDE  = 3'd2,
        ACC_NEAR_PLANE     = 3'd3,
        ACC_OUTSIDE_CAMERA = 3'd4,
        ACC_DEGENERATE     = 3'd5
    } acc_t;

    // Flags that ride alongside the NDC divider
    typedef struct packed {
        logic dir;
        logic degen;
        logic cam_in;
        logic near_hit;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } side_t;

endpackage

`default_nettype wire

### hw/rtl/light_sphere_cull_and_scissor.sv
// Light sphere culling and scissor rectangle pipeline, top level.
//
// Input channel (in_valid/in_ready) carries one item per beat: with kind low
// it writes one transform table word at table_index and produces no result;
// with kind high it classifies one light and produces exactly one result.
// Output channel (out_valid/out_ready) carries acceptance, keep_light,
// intersects_view and the pixel scissor, in input order.
// Configuration is a write port (cfg_wr_en, cfg_addr, cfg_wr_data); the user
// must see that it is written only while the pipeline is empty, as the block
// does not enforce this. A classify beat passes stages 1 to 4, the NDC divider
// and stages 6 to 9, the last holding the output register. The divider resolves
// one quotient bit per stage over 32 + FRACTION_BITS stages (Q16.16 by default).
// Throughput: one beat per cycle while the receiver does not stall.
// A table write takes effect for every classify accepted after it.
// Reset empties the pipeline and loads the register defaults; table words
// are undefined until written.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
`default_nettype none
`include "light_sphere_cull_and_scissor_assert.svh"

module light_sphere_cull_and_scissor #(
    parameter int FRACTION_BITS   = lsc_pkg::FRACTION_BITS_DEF,
    parameter int MAX_SCREEN_SIZE = lsc_pkg::MAX_SCREEN_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [4:0]                        table_index,
    input  logic signed [31:0]                table_value,
    input  logic                              light_is_directional,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic [30:0]                       light_range,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        acceptance,
    output logic                              intersects_view,
    output logic                              keep_light,
    output logic [14:0]                       scissor_x,
    output logic [14:0]                       scissor_y,
    output logic [14:0]                       scissor_w,
    output logic [14:0]                       scissor_h
);

    localparam int FB  = FRACTION_BITS;
    localparam int PRW = 64 - FB;                 // floored product
    localparam int RSW = 66 - FB;                 // row sum
    localparam int NW  = 32 + FB;                 // divider numerator / quotient
    localparam int QS  = NW + 1;                  // signed NDC value
    localparam int EW  = QS + 2;                  // NDC edge sums
    localparam int CLW = FB + 2;                  // clamped span coordinate
    localparam int SZW = $clog2(MAX_SCREEN_SIZE + 1);
    localparam int PW  = CLW + SZW;               // span product
    localparam logic signed [EW-1:0] ONE_E  = EW'(64'd1 << FB);
    localparam logic signed [EW-1:0] TWO_E  = EW'(64'd1 << (FB + 1));
    localparam logic [CLW-1:0]       TWO_C  = CLW'(64'd1 << (FB + 1));
    localparam logic [PW:0]          TWO_M1 = (PW+1)'((64'd1 << (FB + 1)) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] screen_width_reg;
    logic [14:0] screen_height_reg;
    logic [30:0] near_plane_reg;
    logic [15:0] w_epsilon_reg;
    logic        cull_outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= lsc_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= lsc_pkg::RST_SCREEN_HEIGHT;
            near_plane_reg    <= lsc_pkg::RST_NEAR_PLANE;
            w_epsilon_reg     <= lsc_pkg::RST_W_EPSILON;
            cull_outside_reg  <= lsc_pkg::RST_CULL_OUTSIDE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                lsc_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data[14:0];
                lsc_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data[14:0];
                lsc_pkg::CFG_NEAR_PLANE:    near_plane_reg    <= cfg_wr_data[30:0];
                lsc_pkg::CFG_W_EPSILON:     w_epsilon_reg     <= cfg_wr_data[15:0];
                lsc_pkg::CFG_CULL_OUTSIDE:  cull_outside_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp screen extents to the supported range
    logic [15:0]    ext_w;
    logic [15:0]    ext_h;
    logic [SZW-1:0] size_w;
    logic [SZW-1:0] size_h;

    assign ext_w = (screen_width_reg == '0) ? 16'd1 :
                   ({1'b0, screen_width_reg} > 16'(MAX_SCREEN_SIZE)) ? 16'(MAX_SCREEN_SIZE) :
                   {1'b0, screen_width_reg};
    assign ext_h = (screen_height_reg == '0) ? 16'd1 :
                   ({1'b0, screen_height_reg} > 16'(MAX_SCREEN_SIZE)) ? 16'(MAX_SCREEN_SIZE) :
                   {1'b0, screen_height_reg};
    assign size_w = SZW'(ext_w);
    assign size_h = SZW'(ext_h);

    // ------------------------------------------------------------------
    // Handshake and transform table
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic [31:0] tbl_reg [32];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && kind == lsc_pkg::KIND_TABLE_WRITE)
        begin
            tbl_reg[table_index] <= table_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the light
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_dir_reg;
    logic signed [31:0] s1_coord_reg [3];
    logic [30:0]        s1_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && kind == lsc_pkg::KIND_CLASSIFY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dir_reg      <= light_is_directional;
            s1_coord_reg[0] <= pos_x;
            s1_coord_reg[1] <= pos_y;
            s1_coord_reg[2] <= pos_z;
            s1_r_reg        <= light_range;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: matrix products, camera distance squares, radius square
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] s2_prod_next [5][3];
    logic [31:0]           s2_const_next [5];
    logic [63:0]           s2_sq_next [3];
    logic                  s2_sat_next [3];

    for (genvar j = 0; j < 5; j++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            logic signed [63:0] prod_full;
            assign prod_full = $signed(tbl_reg[lsc_pkg::TBL_ROW_STRIDE*j+k]) * s1_coord_reg[k];
            assign s2_prod_next[j][k] = PRW'(prod_full >>> FB);
        end
        assign s2_const_next[j] = tbl_reg[lsc_pkg::TBL_ROW_STRIDE*j+3];
    end

    for (genvar k = 0; k < 3; k++) begin : g_cam
        logic signed [32:0] cd;
        logic [32:0]        cm;
        assign cd = {s1_coord_reg[k][31], s1_coord_reg[k]}
                  - $signed({tbl_reg[lsc_pkg::TBL_CAM_BASE+k][31],
                             tbl_reg[lsc_pkg::TBL_CAM_BASE+k]});
        assign cm = cd[32] ? 33'(-cd) : cd;
        assign s2_sat_next[k] = cm[32];
        assign s2_sq_next[k]  = cm[31:0] * cm[31:0];
    end

    logic                  s2_valid_reg;
    logic                  s2_dir_reg;
    logic [30:0]           s2_r_reg;
    logic [61:0]           s2_rr_reg;
    logic signed [PRW-1:0] s2_prod_reg [5][3];
    logic [31:0]           s2_const_reg [5];
    logic [63:0]           s2_sq_reg [3];
    logic                  s2_sat_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dir_reg   <= s1_dir_reg;
            s2_r_reg     <= s1_r_reg;
            s2_rr_reg    <= s1_r_reg * s1_r_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_const_reg <= s2_const_next;
            s2_sq_reg    <= s2_sq_next;
            s2_sat_reg   <= s2_sat_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: row sums, overflow check, camera-inside test
    // ------------------------------------------------------------------
    logic signed [RSW-1:0] s3_sum [5];
    logic [4:0]            s3_fit;
    logic [65:0]           s3_dist;
    logic                  s3_inside_next;

    for (genvar j = 0; j < 5; j++) begin : g_sum
        assign s3_sum[j] = {{(RSW-PRW){s2_prod_reg[j][0][PRW-1]}}, s2_prod_reg[j][0]}
                         + {{(RSW-PRW){s2_prod_reg[j][1][PRW-1]}}, s2_prod_reg[j][1]}
                         + {{(RSW-PRW){s2_prod_reg[j][2][PRW-1]}}, s2_prod_reg[j][2]}
                         + {{(RSW-32){s2_const_reg[j][31]}}, s2_const_reg[j]};
        assign s3_fit[j] = (&s3_sum[j][RSW-1:31]) | ~(|s3_sum[j][RSW-1:31]);
    end

    assign s3_dist = {2'b0, s2_sq_reg[0]} + {2'b0, s2_sq_reg[1]} + {2'b0, s2_sq_reg[2]};
    assign s3_inside_next = !(s2_sat_reg[0] || s2_sat_reg[1] || s2_sat_reg[2])
                            && (s3_dist <= {4'b0, s2_rr_reg});

    logic                  s3_valid_reg;
    logic                  s3_dir_reg;
    logic [30:0]           s3_r_reg;
    logic signed [31:0]    s3_c_reg [4];
    logic                  s3_fit_reg;
    logic signed [RSW-1:0] s3_vz_reg;
    logic                  s3_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dir_reg    <= s2_dir_reg;
            s3_r_reg      <= s2_r_reg;
            s3_c_reg[0]   <= s3_sum[0][31:0];
            s3_c_reg[1]   <= s3_sum[1][31:0];
            s3_c_reg[2]   <= s3_sum[2][31:0];
            s3_c_reg[3]   <= s3_sum[3][31:0];
            s3_fit_reg    <= &s3_fit[3:0];
            s3_vz_reg     <= s3_sum[4];
            s3_inside_reg <= s3_inside_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |w|, degenerate test, numerator magnitudes, |view z|
    // ------------------------------------------------------------------
    logic [31:0]    s4_aw_next;
    logic [31:0]    s4_mag_next [3];
    logic [RSW-1:0] s4_avz_next;
    logic           s4_degen_next;

    assign s4_aw_next = s3_c_reg[3][31] ? 32'(-s3_c_reg[3]) : s3_c_reg[3];
    for (genvar k = 0; k < 3; k++) begin : g_mag
        assign s4_mag_next[k] = s3_c_reg[k][31] ? 32'(-s3_c_reg[k]) : s3_c_reg[k];
    end
    assign s4_avz_next   = s3_vz_reg[RSW-1] ? RSW'(-s3_vz_reg) : s3_vz_reg;
    assign s4_degen_next = !s3_fit_reg || (s4_aw_next <= {16'd0, w_epsilon_reg});

    logic           s4_valid_reg;
    logic           s4_dir_reg;
    logic [30:0]    s4_r_reg;
    logic [31:0]    s4_aw_reg;
    logic [31:0]    s4_mag_reg [3];
    logic [2:0]     s4_neg_reg;
    logic [RSW-1:0] s4_avz_reg;
    logic           s4_degen_reg;
    logic           s4_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dir_reg    <= s3_dir_reg;
            s4_r_reg      <= s3_r_reg;
            s4_aw_reg     <= s4_aw_next;
            s4_mag_reg    <= s4_mag_next;
            s4_neg_reg    <= {s3_c_reg[2][31], s3_c_reg[1][31], s3_c_reg[0][31]};
            s4_avz_reg    <= s4_avz_next;
            s4_degen_reg  <= s4_degen_next;
            s4_inside_reg <= s3_inside_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider entry: numerators, near plane test, sideband flags
    // ------------------------------------------------------------------
    logic [3:0][NW-1:0]  div_num;
    logic signed [RSW:0] nd_diff;
    logic [RSW:0]        nd_abs;
    lsc_pkg::side_t      div_side_in;

    assign div_num[0] = {s4_mag_reg[0], {FB{1'b0}}};
    assign div_num[1] = {s4_mag_reg[1], {FB{1'b0}}};
    assign div_num[2] = {s4_mag_reg[2], {FB{1'b0}}};
    assign div_num[3] = {1'b0, s4_r_reg, {FB{1'b0}}};

    assign nd_diff = $signed({1'b0, s4_avz_reg}) - $signed({{(RSW-30){1'b0}}, near_plane_reg});
    assign nd_abs  = nd_diff[RSW] ? (RSW+1)'(-nd_diff) : nd_diff;

    always_comb
    begin
        div_side_in.dir      = s4_dir_reg;
        div_side_in.degen    = s4_degen_reg;
        div_side_in.cam_in   = s4_inside_reg;
        div_side_in.near_hit = nd_abs <= {{(RSW-30){1'b0}}, s4_r_reg};
        div_side_in.neg_x    = s4_neg_reg[0];
        div_side_in.neg_y    = s4_neg_reg[1];
        div_side_in.neg_z    = s4_neg_reg[2];
    end

    logic               div_valid;
    logic [3:0][NW-1:0] div_quo;
    lsc_pkg::side_t     div_side;

    lsc_div #(
        .NUM_W (NW),
        .LANES (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .num       (div_num),
        .den       (s4_aw_reg),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // ------------------------------------------------------------------
    // Stage 6: restore quotient signs
    // ------------------------------------------------------------------
    logic signed [QS-1:0] s6_n_next [3];
    logic [2:0]           div_neg;

    assign div_neg = {div_side.neg_z, div_side.neg_y, div_side.neg_x};
    for (genvar k = 0; k < 3; k++) begin : g_sign
        assign s6_n_next[k] = div_neg[k] ? QS'(-$signed({1'b0, div_quo[k]}))
                                         : $signed({1'b0, div_quo[k]});
    end

    logic                 s6_valid_reg;
    lsc_pkg::side_t       s6_side_reg;
    logic signed [QS-1:0] s6_n_reg [3];
    logic [NW-1:0]        s6_rn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg <= div_side;
            s6_n_reg    <= s6_n_next;
            s6_rn_reg   <= div_quo[3];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: frustum test, classification, span clamps
    // ------------------------------------------------------------------
    logic signed [EW-1:0] s7_lo [3];
    logic signed [EW-1:0] s7_hi [3];
    logic [CLW-1:0]       s7_a_next [2];
    logic [CLW-1:0]       s7_b_next [2];
    logic                 s7_outside;

    for (genvar k = 0; k < 3; k++) begin : g_edge
        logic signed [EW-1:0] ne;
        logic signed [EW-1:0] re;
        assign ne       = {{2{s6_n_reg[k][QS-1]}}, s6_n_reg[k]};
        assign re       = $signed({3'b0, s6_rn_reg});
        assign s7_lo[k] = ne - re;
        assign s7_hi[k] = ne + re;
    end

    for (genvar k = 0; k < 2; k++) begin : g_clamp
        logic signed [EW-1:0] av;
        logic signed [EW-1:0] bv;
        assign av = s7_lo[k] + ONE_E;
        assign bv = s7_hi[k] + ONE_E;
        assign s7_a_next[k] = av[EW-1] ? '0 : (av > TWO_E) ? TWO_C : av[CLW-1:0];
        assign s7_b_next[k] = bv[EW-1] ? '0 : (bv > TWO_E) ? TWO_C : bv[CLW-1:0];
    end

    assign s7_outside = (s7_hi[0] < -ONE_E) || (s7_lo[0] > ONE_E)
                     || (s7_hi[1] < -ONE_E) || (s7_lo[1] > ONE_E)
                     || s7_hi[2][EW-1]      || (s7_lo[2] > ONE_E);

    lsc_pkg::acc_t s7_acc_next;
    logic          s7_keep_next;
    logic          s7_full_next;
    logic          s7_span_next;

    // Pick the acceptance kind
    always_comb
    begin
        s7_acc_next  = lsc_pkg::ACC_DEGENERATE;
        s7_keep_next = 1'b1;
        s7_full_next = 1'b0;
        s7_span_next = 1'b0;
        if (s6_side_reg.dir)
        begin
            s7_acc_next  = lsc_pkg::ACC_FULL_VIEW;
            s7_full_next = 1'b1;
        end
        else if (s6_side_reg.degen)
        begin
            s7_acc_next = lsc_pkg::ACC_DEGENERATE;
        end
        else if (s7_outside && !s6_side_reg.cam_in)
        begin
            if (cull_outside_reg)
            begin
                s7_acc_next  = lsc_pkg::ACC_CULLED;
                s7_keep_next = 1'b0;
            end
            else
            begin
                s7_acc_next = lsc_pkg::ACC_OUTSIDE_CAMERA;
            end
        end
        else
        begin
            s7_span_next = 1'b1;
            if (s6_side_reg.cam_in)
            begin
                s7_acc_next = lsc_pkg::ACC_CAMERA_INSIDE;
            end
            else if (s6_side_reg.near_hit)
            begin
                s7_acc_next = lsc_pkg::ACC_NEAR_PLANE;
            end
            else
            begin
                s7_acc_next = lsc_pkg::ACC_OUTSIDE_CAMERA;
            end
        end
    end

    logic           s7_valid_reg;
    lsc_pkg::acc_t  s7_acc_reg;
    logic           s7_keep_reg;
    logic           s7_full_reg;
    logic           s7_span_reg;
    logic [CLW-1:0] s7_a_reg [2];
    logic [CLW-1:0] s7_b_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_acc_reg  <= s7_acc_next;
            s7_keep_reg <= s7_keep_next;
            s7_full_reg <= s7_full_next;
            s7_span_reg <= s7_span_next;
            s7_a_reg    <= s7_a_next;
            s7_b_reg    <= s7_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: scale span edges by the screen size
    // ------------------------------------------------------------------
    logic          s8_valid_reg;
    lsc_pkg::acc_t s8_acc_reg;
    logic          s8_keep_reg;
    logic          s8_full_reg;
    logic          s8_span_reg;
    logic [PW-1:0] s8_pa_reg [2];
    logic [PW-1:0] s8_pb_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_acc_reg   <= s7_acc_reg;
            s8_keep_reg  <= s7_keep_reg;
            s8_full_reg  <= s7_full_reg;
            s8_span_reg  <= s7_span_reg;
            s8_pa_reg[0] <= s7_a_reg[0] * size_w;
            s8_pb_reg[0] <= s7_b_reg[0] * size_w;
            s8_pa_reg[1] <= s7_a_reg[1] * size_h;
            s8_pb_reg[1] <= s7_b_reg[1] * size_h;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: floor/ceil edges and output register
    // ------------------------------------------------------------------
    logic [SZW:0]   sp_lo  [2];
    logic [PW:0]    sp_sum [2];
    logic [SZW+1:0] sp_hi  [2];
    logic [SZW+1:0] sp_len [2];

    for (genvar k = 0; k < 2; k++) begin : g_span
        assign sp_lo[k]  = s8_pa_reg[k][PW-1:FB+1];
        assign sp_sum[k] = {1'b0, s8_pb_reg[k]} + TWO_M1;
        assign sp_hi[k]  = sp_sum[k][PW:FB+1];
        assign sp_len[k] = (sp_hi[k] > {1'b0, sp_lo[k]}) ? sp_hi[k] - {1'b0, sp_lo[k]}
                                                         : (SZW+2)'(1);
    end

    lsc_pkg::acc_t acceptance_reg;
    logic          intersects_view_reg;
    logic          keep_light_reg;
    logic [14:0]   scissor_x_reg;
    logic [14:0]   scissor_y_reg;
    logic [14:0]   scissor_w_reg;
    logic [14:0]   scissor_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acceptance_reg      <= s8_acc_reg;
            keep_light_reg      <= s8_keep_reg;
            intersects_view_reg <= s8_full_reg || s8_span_reg;
            if (s8_full_reg)
            begin
                scissor_x_reg <= '0;
                scissor_y_reg <= '0;
                scissor_w_reg <= 15'(size_w);
                scissor_h_reg <= 15'(size_h);
            end
            else if (s8_span_reg)
            begin
                scissor_x_reg <= 15'(sp_lo[0]);
                scissor_y_reg <= 15'(sp_lo[1]);
                scissor_w_reg <= 15'(sp_len[0]);
                scissor_h_reg <= 15'(sp_len[1]);
            end
            else
            begin
                scissor_x_reg <= '0;
                scissor_y_reg <= '0;
                scissor_w_reg <= '0;
                scissor_h_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign acceptance      = acceptance_reg;
    assign intersects_view = intersects_view_reg;
    assign keep_light      = keep_light_reg;
    assign scissor_x       = scissor_x_reg;
    assign scissor_y       = scissor_y_reg;
    assign scissor_w       = scissor_w_reg;
    assign scissor_h       = scissor_h_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSC_ASSERT_IMPL(a_culled_dropped, clk, rst_n, out_valid_reg && acceptance_reg == lsc_pkg::ACC_CULLED, !keep_light_reg)
    `LSC_ASSERT_IMPL(a_dropped_is_culled, clk, rst_n, out_valid_reg && !keep_light_reg, acceptance_reg == lsc_pkg::ACC_CULLED && !intersects_view_reg)
    `LSC_ASSERT_IMPL(a_scissor_nonempty, clk, rst_n, out_valid_reg && intersects_view_reg, scissor_w_reg != '0 && scissor_h_reg != '0)
    `LSC_ASSERT_IMPL(a_scissor_cleared, clk, rst_n, out_valid_reg && !intersects_view_reg, scissor_w_reg == '0 && scissor_h_reg == '0 && scissor_x_reg == '0)
    `LSC_ASSERT_NEXT(a_table_write_no_item, clk, rst_n, en && !(in_valid && kind == lsc_pkg::KIND_CLASSIFY), !s1_valid_reg)

endmodule

`default_nettype wire

### hw/rtl/lsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes on one divisor.
`default_nettype none

module lsc_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = lsc_pkg::DEN_W,
    parameter int LANES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]                  den,
    input  lsc_pkg::side_t                    side_in,
    output logic                              out_valid,
    output logic [LANES-1:0][NUM_W-1:0]       quo,
    output lsc_pkg::side_t                    side_out
);

    // Numerator bits shift out at the top while quotient bits shift in at the bottom
    logic [LANES-1:0][NUM_W-1:0] nq_reg   [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [NUM_W];
    logic [DEN_W-1:0]            den_reg  [NUM_W];
    lsc_pkg::side_t              side_reg [NUM_W];
    logic                        vld_reg  [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [LANES-1:0][NUM_W-1:0] nq_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [DEN_W-1:0]            den_in;
        lsc_pkg::side_t              side_s;
        logic                        vld_in;
        logic [LANES-1:0][NUM_W-1:0] nq_next;
        logic [LANES-1:0][DEN_W-1:0] rem_next;

        // Select stage source
        if (s == 0) begin : g_first
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
            assign side_s = side_in;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign nq_in  = nq_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign side_s = side_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        // Trial subtract per lane
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           qb;
            assign trial       = {rem_in[l], nq_in[l][NUM_W-1]};
            assign diff        = trial - {1'b0, den_in};
            assign qb          = ~diff[DEN_W];
            assign rem_next[l] = qb ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign nq_next[l]  = {nq_in[l][NUM_W-2:0], qb};
        end

        // Advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[s]   <= nq_next;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

### test/light_sphere_cull_and_scissor_tb.sv
// Self-checking testbench for the light sphere culling and scissor pipeline.
`timescale 1ns / 100ps

module light_sphere_cull_and_scissor_tb;

    localparam longint ONE       = 64'sd65536;
    localparam int     FRAC      = 16;
    localparam int     MAX_SIZE  = 16384;
    localparam int     LATENCY   = 55;
    localparam int     SETTLE    = LATENCY + 10;
    localparam int     CYCLE_CAP = 1500000;
    localparam int     W_ROW     = 12;
    localparam int     VIEW_Z    = 16;

    typedef struct {
        logic        kind;
        logic [4:0]  idx;
        logic [31:0] value;
        logic        dir;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] range;
    } light_item_t;

    typedef struct {
        lsc_pkg::acc_t acc;
        logic          inter;
        logic          keep;
        logic [14:0]   sx;
        logic [14:0]   sy;
        logic [14:0]   sw;
        logic [14:0]   sh;
    } light_verdict_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [lsc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lsc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           kind = 1'b0;
    logic [4:0]                     table_index = '0;
    logic signed [31:0]             table_value = '0;
    logic                           light_is_directional = 1'b0;
    logic signed [31:0]             pos_x = '0;
    logic signed [31:0]             pos_y = '0;
    logic signed [31:0]             pos_z = '0;
    logic [30:0]                    light_range = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [2:0]                     acceptance;
    logic                           intersects_view;
    logic                           keep_light;
    logic [14:0]                    scissor_x;
    logic [14:0]                    scissor_y;
    logic [14:0]                    scissor_w;
    logic [14:0]                    scissor_h;

    light_sphere_cull_and_scissor i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_addr             (cfg_addr),
        .cfg_wr_data          (cfg_wr_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .kind                 (kind),
        .table_index          (table_index),
        .table_value          (table_value),
        .light_is_directional (light_is_directional),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .pos_z                (pos_z),
        .light_range          (light_range),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .acceptance           (acceptance),
        .intersects_view      (intersects_view),
        .keep_light           (keep_light),
        .scissor_x            (scissor_x),
        .scissor_y            (scissor_y),
        .scissor_w            (scissor_w),
        .scissor_h            (scissor_h)
    );

    // Shadow copy of the transform table and registers
    logic [31:0] xform_words [32];
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [30:0] near_reg;
    logic [15:0] eps_reg;
    logic        cull_reg;

    light_item_t    pend_q [$];
    light_verdict_t verdict_q [$];
    light_item_t    on_bus;
    int             fail_count;
    int             light_beats;
    int             table_beats;
    int             verdicts_seen;
    int             acc_hits [8];
    int             in_gap;
    int             out_stall;
    bit             burst_mode;
    longint         cycle_count;

    always #4 clk = ~clk;

    // Append one item to the pending stimulus
    function automatic void enqueue(light_item_t it);
        pend_q.insert(pend_q.size(), it);
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint tbl(int i);
        return longint'(signed'(xform_words[i]));
    endfunction

    function automatic longint row_dot(int b, longint x, longint y, longint z);
        return ((tbl(b) * x) >>> FRAC) + ((tbl(b + 1) * y) >>> FRAC)
             + ((tbl(b + 2) * z) >>> FRAC) + tbl(b + 3);
    endfunction

    function automatic longint unsigned sq_sat(longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : longint'(d);
        if (m >= 64'h1_0000_0000) return '1;
        return m * m;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        return (a > ~b) ? '1 : a + b;
    endfunction

    function automatic bit fits_word(longint v);
        return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    function automatic longint unsigned clamp_size(logic [14:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIZE) return MAX_SIZE;
        return s;
    endfunction

    // Map one NDC interval onto the pixel grid: floor left, ceil right
    function automatic void pixel_span(input longint c, input longint rn,
                                       input longint unsigned size,
                                       output logic [14:0] lo, output logic [14:0] len);
        longint a;
        longint b;
        longint unsigned l;
        longint unsigned h;
        a = c - rn + ONE;
        b = c + rn + ONE;
        if (a < 0) a = 0;
        if (a > 2 * ONE) a = 2 * ONE;
        if (b < 0) b = 0;
        if (b > 2 * ONE) b = 2 * ONE;
        l = (longint'(a) * size) / (2 * ONE);
        h = (longint'(b) * size + 2 * ONE - 1) / (2 * ONE);
        lo = l[14:0];
        len = (h > l + 1) ? 15'(h - l) : 15'd1;
    endfunction

    // Classify one light against the shadow table and registers
    function automatic light_verdict_t classify_light(light_item_t it);
        light_verdict_t v;
        longint x, y, z, r, cx, cy, cz, cw, aw, nx, ny, nz, rn, avz, nd;
        longint unsigned d2, sw, sh;
        bit in_sphere, out_view;
        v.acc = lsc_pkg::ACC_DEGENERATE;
        v.inter = 1'b0;
        v.keep = 1'b1;
        v.sx = '0;
        v.sy = '0;
        v.sw = '0;
        v.sh = '0;
        sw = clamp_size(width_reg);
        sh = clamp_size(height_reg);
        if (it.dir) begin
            v.acc = lsc_pkg::ACC_FULL_VIEW;
            v.inter = 1'b1;
            v.sw = sw[14:0];
            v.sh = sh[14:0];
            return v;
        end
        x = longint'(signed'(it.x));
        y = longint'(signed'(it.y));
        z = longint'(signed'(it.z));
        r = longint'(it.range);
        d2 = add_sat(add_sat(sq_sat(x - tbl(lsc_pkg::TBL_CAM_BASE)),
                             sq_sat(y - tbl(lsc_pkg::TBL_CAM_BASE + 1))),
                     sq_sat(z - tbl(lsc_pkg::TBL_CAM_BASE + 2)));
        in_sphere = d2 <= longint'(r * r);
        avz = row_dot(VIEW_Z, x, y, z);
        if (avz < 0) avz = -avz;
        nd = avz - longint'(near_reg);
        if (nd < 0) nd = -nd;
        cx = row_dot(0, x, y, z);
        cy = row_dot(4, x, y, z);
        cz = row_dot(8, x, y, z);
        cw = row_dot(W_ROW, x, y, z);
        if (!fits_word(cx) || !fits_word(cy) || !fits_word(cz) || !fits_word(cw)) return v;
        aw = (cw < 0) ? -cw : cw;
        if (aw <= longint'(eps_reg)) return v;
        nx = (cx * ONE) / aw;
        ny = (cy * ONE) / aw;
        nz = (cz * ONE) / aw;
        rn = (r * ONE) / aw;
        out_view = nx + rn < -ONE || nx - rn > ONE || ny + rn < -ONE || ny - rn > ONE
                || nz + rn < 0 || nz - rn > ONE;
        if (out_view && !in_sphere) begin
            v.acc = cull_reg ? lsc_pkg::ACC_CULLED : lsc_pkg::ACC_OUTSIDE_CAMERA;
            v.keep = !cull_reg;
            return v;
        end
        pixel_span(nx, rn, sw, v.sx, v.sw);
        pixel_span(ny, rn, sh, v.sy, v.sh);
        v.inter = 1'b1;
        v.acc = in_sphere ? lsc_pkg::ACC_CAMERA_INSIDE
              : (nd <= r ? lsc_pkg::ACC_NEAR_PLANE : lsc_pkg::ACC_OUTSIDE_CAMERA);
        return v;
    endfunction

    // Drive input beats; predict each one at the edge where it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                if (on_bus.kind == lsc_pkg::KIND_TABLE_WRITE) begin
                    xform_words[on_bus.idx] = on_bus.value;
                    table_beats++;
                end else begin
                    verdict_q.insert(verdict_q.size(), classify_light(on_bus));
                    light_beats++;
                end
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    on_bus = pend_q.pop_front();
                    kind <= on_bus.kind;
                    table_index <= on_bus.idx;
                    table_value <= on_bus.value;
                    light_is_directional <= on_bus.dir;
                    pos_x <= on_bus.x;
                    pos_y <= on_bus.y;
                    pos_z <= on_bus.z;
                    light_range <= on_bus.range;
                    in_valid <= 1'b1;
                    in_gap = gap_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Check output beats in order; throttle out_ready
    always @(posedge clk) begin
        light_verdict_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, acceptance %0d", $time, acceptance);
                    fail_count++;
                end else begin
                    e = verdict_q.pop_front();
                    acc_hits[e.acc]++;
                    check_field("acceptance", e.acc, acceptance);
                    check_field("intersects_view", e.inter, intersects_view);
                    check_field("keep_light", e.keep, keep_light);
                    check_field("scissor_x", e.sx, scissor_x);
                    check_field("scissor_y", e.sy, scissor_y);
                    check_field("scissor_w", e.sw, scissor_w);
                    check_field("scissor_h", e.sh, scissor_h);
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall = gap_len();
            end
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdict_q.size());
            $display("light_sphere_cull_and_scissor regression: fail");
            $finish;
        end
    end

    function automatic light_item_t table_item(int idx, int val);
        light_item_t it;
        it = '{default: '0};
        it.kind = lsc_pkg::KIND_TABLE_WRITE;
        it.idx = 5'(idx);
        it.value = 32'(val);
        return it;
    endfunction

    function automatic light_item_t light_item(bit dir, int x, int y, int z, int rng);
        light_item_t it;
        it = '{default: '0};
        it.kind = lsc_pkg::KIND_CLASSIFY;
        it.dir = dir;
        it.x = 32'(x);
        it.y = 32'(y);
        it.z = 32'(z);
        it.range = 31'(rng);
        return it;
    endfunction

    function automatic int rnd_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic light_item_t noise_item();
        light_item_t it;
        it.kind = 1'($urandom);
        it.idx = 5'($urandom);
        it.value = $urandom;
        it.dir = 1'($urandom);
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        it.range = 31'($urandom);
        return it;
    endfunction

    // Queue a plausible perspective-like transform and camera
    task automatic queue_scene();
        int i;
        for (i = 0; i < 16; i++) begin
            if (i % 5 == 0) enqueue(table_item(i, int'($urandom_range(32768, 196608))));
            else if (i % 4 == 3) enqueue(table_item(i, rnd_span(8 * ONE)));
            else enqueue(table_item(i, rnd_span(ONE / 4)));
        end
        // w follows view depth, sign chosen at random
        enqueue(table_item(W_ROW + 2, ($urandom & 1) ? -ONE : ONE));
        enqueue(table_item(W_ROW + 3, rnd_span(2 * ONE)));
        for (i = 0; i < 4; i++)
            enqueue(table_item(VIEW_Z + i, (i == 2) ? -ONE : rnd_span(ONE / 2)));
        for (i = 0; i < 3; i++)
            enqueue(table_item(lsc_pkg::TBL_CAM_BASE + i, rnd_span(16 * ONE)));
    endtask

    function automatic light_item_t scene_light();
        int p;
        int rng;
        p = $urandom_range(0, 99);
        if (p < 60) rng = $urandom_range(0, 8 * ONE);
        else if (p < 95) rng = $urandom_range(0, 64 * ONE);
        else rng = $urandom_range(0, 32'h7FFF_FFFF);
        return light_item($urandom_range(0, 9) == 0, rnd_span(48 * ONE), rnd_span(48 * ONE),
                          rnd_span(48 * ONE), rng);
    endfunction

    task automatic wait_idle();
        while (pend_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; the caller lowers the enable after the last write
    task automatic write_reg(lsc_pkg::cfg_index_t a, int unsigned d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= lsc_pkg::CFG_DATA_W'(d);
        case (a)
            lsc_pkg::CFG_SCREEN_WIDTH:  width_reg = d[14:0];
            lsc_pkg::CFG_SCREEN_HEIGHT: height_reg = d[14:0];
            lsc_pkg::CFG_NEAR_PLANE:    near_reg = d[30:0];
            lsc_pkg::CFG_W_EPSILON:     eps_reg = d[15:0];
            lsc_pkg::CFG_CULL_OUTSIDE:  cull_reg = d[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(int unsigned w, int unsigned h, int unsigned n,
                             int unsigned e, int unsigned c);
        write_reg(lsc_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(lsc_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(lsc_pkg::CFG_NEAR_PLANE, n);
        write_reg(lsc_pkg::CFG_W_EPSILON, e);
        write_reg(lsc_pkg::CFG_CULL_OUTSIDE, c);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 12) enqueue(noise_item());
            else if ($urandom_range(0, 99) < 4) queue_scene();
            else enqueue(scene_light());
        end
    endtask

    initial begin
        int ph;
        width_reg = lsc_pkg::RST_SCREEN_WIDTH;
        height_reg = lsc_pkg::RST_SCREEN_HEIGHT;
        near_reg = lsc_pkg::RST_NEAR_PLANE;
        eps_reg = lsc_pkg::RST_W_EPSILON;
        cull_reg = lsc_pkg::RST_CULL_OUTSIDE;
        foreach (xform_words[i]) xform_words[i] = '0;
        burst_mode = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity view with w = 1, camera behind the origin
        for (int i = 0; i < 23; i++)
            enqueue(table_item(i, (i % 5 == 0 || i == 18) ? ONE :
                                  (i == 22 ? -10 * ONE : 0)));
        enqueue(light_item(1'b1, 0, 0, 0, 0));
        enqueue(light_item(1'b0, 0, 0, ONE / 2, ONE / 10));
        enqueue(light_item(1'b0, 0, 0, ONE / 2, 0));
        enqueue(light_item(1'b0, 0, 0, ONE / 10, ONE / 4));
        enqueue(light_item(1'b0, 0, 0, -10 * ONE, ONE));
        enqueue(light_item(1'b0, 5 * ONE, 0, ONE / 2, ONE / 8));
        enqueue(light_item(1'b0, ONE / 2, -ONE / 2, ONE / 2, 32'h7FFF_FFFF));
        enqueue(light_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        enqueue(light_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE));
        // Collapse w to zero: degenerate, then restore
        enqueue(table_item(15, 0));
        enqueue(light_item(1'b0, 0, 0, ONE / 2, ONE));
        enqueue(table_item(15, 5));
        enqueue(light_item(1'b0, 0, 0, ONE / 2, ONE));
        enqueue(table_item(15, ONE));
        enqueue(table_item(27, 32'hDEAD_BEEF));
        wait_idle();

        // Register settings: reset defaults, then extremes, then random ones
        for (ph = 0; ph < 7; ph++) begin
            burst_mode = (ph == 2);
            case (ph)
                0: ;
                1: write_all(0, 0, 0, 0, 0);
                2: write_all(32767, 32767, 32'h7FFF_FFFF, 65535, 1);
                3: write_all(16384, 1, 6554, 0, 0);
                4: write_all(1, 16384, ONE / 2, 65535, 0);
                default: write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 4 * ONE), $urandom_range(0, 65535),
                                   $urandom_range(0, 1));
            endcase
            @(posedge clk);
            queue_scene();
            queue_random(145);
            wait_idle();
        end

        $display("%0d light beats, %0d table beats, %0d results checked over 7 settings",
                 light_beats, table_beats, verdicts_seen);
        $display("kinds: full %0d culled %0d inside %0d near %0d outside %0d degenerate %0d",
                 acc_hits[lsc_pkg::ACC_FULL_VIEW], acc_hits[lsc_pkg::ACC_CULLED],
                 acc_hits[lsc_pkg::ACC_CAMERA_INSIDE], acc_hits[lsc_pkg::ACC_NEAR_PLANE],
                 acc_hits[lsc_pkg::ACC_OUTSIDE_CAMERA], acc_hits[lsc_pkg::ACC_DEGENERATE]);
        if (fail_count == 0)
            $display("light_sphere_cull_and_scissor regression: pass");
        else
            $display("light_sphere_cull_and_scissor regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_div.sv
hw/rtl/light_sphere_cull_and_scissor.sv
test/light_sphere_cull_and_scissor_tb.sv
